@@ rtl/core/ssfb_pkg.sv @@
// Shared types, constants and lookup functions for the seven-segment frame builder.
// Depends on nothing; every module of the block refers to it by scoped names.
package ssfb_pkg;

  // Sizing limits over the whole parameter range
  localparam int SEG_MAX       = 6;
  localparam int CNT_W         = $clog2(SEG_MAX + 1);
  localparam int DIGITS_DEF    = 3;
  localparam int CLEAR_DEF     = 6;
  localparam int QUEUE_DEF     = 2;
  localparam int CFG_BYTES     = 3;

  // Command codes
  localparam logic [2:0] CMD_SHOW   = 3'd0;
  localparam logic [2:0] CMD_DOT    = 3'd1;
  localparam logic [2:0] CMD_CFG    = 3'd2;
  localparam logic [2:0] CMD_BRIGHT = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Frame bytes
  localparam logic [7:0] BYTE_DATA_WRITE = 8'h40;
  localparam logic [7:0] BYTE_ADDRESS    = 8'hC0;
  localparam logic [7:0] BYTE_BRIGHT     = 8'h87;
  localparam logic [7:0] DOT_BIT         = 8'h80;
  localparam logic [7:0] SEG_BLANK       = 8'h00;
  localparam logic [3:0] LEVEL_MAX       = 4'd8;

  // Reciprocal constants for divide by ten
  localparam logic [31:0] RECIP16       = 32'd52429;
  localparam int          RECIP16_SHIFT = 19;
  localparam logic [15:0] RECIP8        = 16'd205;
  localparam int          RECIP8_SHIFT  = 11;

  // One queued job: either a full display update or a single brightness frame
  typedef struct packed {
    logic                          bright;
    logic [CNT_W-1:0]              cnt;
    logic [SEG_MAX-1:0][7:0]       segs;
  } desc_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [16:0] pow10(input logic [CNT_W-1:0] i);
    logic [16:0] p;
    case (i)
      3'd0: p = 17'd1;
      3'd1: p = 17'd10;
      3'd2: p = 17'd100;
      3'd3: p = 17'd1000;
      3'd4: p = 17'd10000;
      default: p = 17'd100000;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/core/ssfb_front.sv @@
// Front end of the frame builder: accepts commands, keeps display state and
// converts digits one per cycle into a job descriptor. Depends on ssfb_pkg.
module ssfb_front #(
  parameter int DIGITS      = ssfb_pkg::DIGITS_DEF,
  parameter int CLEAR_BYTES = ssfb_pkg::CLEAR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          cmd,
  input  logic [15:0]         number,
  input  logic [1:0]          dot_select,
  input  logic [7:0]          param_num,
  input  logic [3:0]          level,
  output logic                push,
  output ssfb_pkg::desc_t     push_desc,
  input  logic                q_full
);

  localparam logic [2:0] W_NONE   = 3'd0;
  localparam logic [2:0] W_SHOW   = 3'd1;
  localparam logic [2:0] W_CFG    = 3'd2;
  localparam logic [2:0] W_BRIGHT = 3'd3;
  localparam logic [2:0] W_CLEAR  = 3'd4;
  localparam int CW = ssfb_pkg::CNT_W;

  logic                                  busy_r;
  logic [2:0]                            wk_r;
  logic [CW-1:0]                         idx_r;
  logic [15:0]                           v_r;
  logic [7:0]                            param_r;
  logic [15:0]                           shown_value_r;
  logic [1:0]                            dot_pos_r;
  logic [ssfb_pkg::SEG_MAX-1:0][7:0]     seg_r;

  logic [CW-1:0] steps;
  logic          done;
  logic          finish;
  logic          acc;
  logic [2:0]    wk_dec;
  logic [31:0]   prod;
  logic [15:0]   q16;
  logic [15:0]   rem16;
  logic [15:0]   prodp;
  logic [7:0]    qp;
  logic [7:0]    remp;
  logic [7:0]    digit_byte;
  logic [3:0]    lvl;

  always_comb begin
    case (wk_r)
      W_SHOW:  steps = CW'(DIGITS);
      W_CFG:   steps = CW'(1);
      default: steps = '0;
    endcase
    done      = (idx_r == steps);
    finish    = busy_r && done && ((wk_r == W_NONE) || !q_full);
    push      = busy_r && done && (wk_r != W_NONE) && !q_full;
    in_tready = !busy_r || finish;
    acc       = in_tvalid && in_tready;
  end

  always_comb begin
    case (cmd)
      ssfb_pkg::CMD_SHOW:   wk_dec = W_SHOW;
      ssfb_pkg::CMD_DOT:    wk_dec = W_SHOW;
      ssfb_pkg::CMD_CFG:    wk_dec = W_CFG;
      ssfb_pkg::CMD_BRIGHT: wk_dec = W_BRIGHT;
      ssfb_pkg::CMD_CLEAR:  wk_dec = W_CLEAR;
      default:              wk_dec = W_NONE;
    endcase
    lvl = (level > ssfb_pkg::LEVEL_MAX) ? ssfb_pkg::LEVEL_MAX : level;
  end

  // Divide by ten through reciprocal multiply, remainder by shift-add
  always_comb begin
    prod  = {16'd0, v_r} * ssfb_pkg::RECIP16;
    q16   = 16'(prod >> ssfb_pkg::RECIP16_SHIFT);
    rem16 = v_r - (q16 << 3) - (q16 << 1);
    prodp = {8'd0, param_r} * ssfb_pkg::RECIP8;
    qp    = 8'(prodp >> ssfb_pkg::RECIP8_SHIFT);
    remp  = param_r - (qp << 3) - (qp << 1);

    digit_byte = ssfb_pkg::seg_code(rem16[3:0]);
    if ((dot_pos_r != 2'd0) && (CW'(dot_pos_r) - CW'(1) == idx_r)) begin
      digit_byte = digit_byte | ssfb_pkg::DOT_BIT;
    end
    // blank leading zeros, dot included
    if ((idx_r != '0) && ({1'b0, shown_value_r} < ssfb_pkg::pow10(idx_r))) begin
      digit_byte = ssfb_pkg::SEG_BLANK;
    end
  end

  always_comb begin
    push_desc.bright = (wk_r == W_BRIGHT);
    push_desc.segs   = seg_r;
    case (wk_r)
      W_SHOW:  push_desc.cnt = CW'(DIGITS);
      W_CFG:   push_desc.cnt = CW'(ssfb_pkg::CFG_BYTES);
      W_CLEAR: push_desc.cnt = CW'(CLEAR_BYTES);
      default: push_desc.cnt = CW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      wk_r          <= W_NONE;
      idx_r         <= '0;
      shown_value_r <= '0;
      dot_pos_r     <= '0;
    end else if (acc) begin
      busy_r  <= 1'b1;
      wk_r    <= wk_dec;
      idx_r   <= '0;
      param_r <= param_num;
      if (cmd == ssfb_pkg::CMD_BRIGHT) begin
        seg_r <= {{((ssfb_pkg::SEG_MAX - 1) * 8){1'b0}},
                  ssfb_pkg::BYTE_BRIGHT + {4'd0, lvl}};
      end else begin
        seg_r <= '0;
      end
      if (cmd == ssfb_pkg::CMD_DOT) begin
        v_r       <= shown_value_r;
        dot_pos_r <= dot_select;
      end else begin
        v_r <= number;
      end
      if (cmd == ssfb_pkg::CMD_SHOW) begin
        shown_value_r <= number;
      end
    end else if (finish) begin
      busy_r <= 1'b0;
    end else if (busy_r && !done) begin
      // one digit per cycle
      idx_r <= idx_r + CW'(1);
      if (wk_r == W_CFG) begin
        seg_r[0] <= ssfb_pkg::seg_code(rem16[3:0]);
        seg_r[2] <= ssfb_pkg::seg_code(remp[3:0]) | ssfb_pkg::DOT_BIT;
      end else begin
        seg_r[idx_r] <= digit_byte;
        v_r          <= q16;
      end
    end
  end

endmodule

@@ rtl/core/ssfb_queue.sv @@
// Small descriptor queue between the front and back ends of the frame builder.
// Depends on ssfb_pkg for the descriptor type.
module ssfb_queue #(
  parameter int DEPTH = ssfb_pkg::QUEUE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ssfb_pkg::desc_t  push_desc,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ssfb_pkg::desc_t  head_desc
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ssfb_pkg::desc_t   mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/ssfb_back.sv @@
// Back end of the frame builder: walks a queued job and emits one framed byte
// per cycle into the output register unless out_tready holds it. Depends on ssfb_pkg.
module ssfb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ssfb_pkg::desc_t  head_desc,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int CW = ssfb_pkg::CNT_W;

  logic [CW-1:0] pos_r;
  logic          out_tvalid_r;
  logic [7:0]    out_tdata_r;
  logic [1:0]    out_tuser_r;
  logic          out_tlast_r;

  logic          load;
  logic          at_end;
  logic [CW-1:0] sel;
  logic [7:0]    byte_nxt;
  logic          start_nxt;
  logic          end_nxt;

  always_comb begin
    load   = head_valid && (!out_tvalid_r || out_tready);
    at_end = head_desc.bright || (pos_r == head_desc.cnt + CW'(1));
    pop    = load && at_end;
    sel    = head_desc.cnt + CW'(1) - pos_r;
    if (head_desc.bright) begin
      byte_nxt  = head_desc.segs[0];
      start_nxt = 1'b1;
      end_nxt   = 1'b1;
    end else if (pos_r == '0) begin
      byte_nxt  = ssfb_pkg::BYTE_DATA_WRITE;
      start_nxt = 1'b1;
      end_nxt   = 1'b1;
    end else if (pos_r == CW'(1)) begin
      byte_nxt  = ssfb_pkg::BYTE_ADDRESS;
      start_nxt = 1'b1;
      end_nxt   = 1'b0;
    end else begin
      byte_nxt  = head_desc.segs[sel];
      start_nxt = 1'b0;
      end_nxt   = at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        out_tvalid_r <= 1'b1;
        pos_r        <= at_end ? '0 : pos_r + CW'(1);
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= byte_nxt;
      out_tuser_r <= {end_nxt, start_nxt};
      out_tlast_r <= at_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ rtl/core/seven_segment_frame_builder_unit.sv @@
// Unused command codes emit nothing. Throughput: one output byte per cycle while
// out_tready does not stall the output; a display update is DIGITS+2 bytes long
// (CLEAR_BYTES+2 for clear, 5 for config view, 1 for brightness), set by the byte
// sequencer of the back end. The front end converts one digit per cycle.
// Reset: synchronous, active low; clears shown value, dot position, queue and output.
module seven_segment_frame_builder_unit #(
  parameter int DIGITS      = ssfb_pkg::DIGITS_DEF,
  parameter int CLEAR_BYTES = ssfb_pkg::CLEAR_DEF,
  parameter int QUEUE_DEPTH = ssfb_pkg::QUEUE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // number[15:0], dot_select[17:16], param_num[25:18],
                                 // level[29:26], zero fill [31:30]
  input  logic [2:0]  in_tuser,  // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // tx_byte[7:0]
  output logic [1:0]  out_tuser, // frame_start[0], frame_end[1]
  output logic        out_tlast
);

  // Front to queue
  logic            push;
  ssfb_pkg::desc_t push_desc;
  logic            q_full;
  // Queue to back
  logic            pop;
  logic            head_valid;
  ssfb_pkg::desc_t head_desc;

  // Front: take a transaction, update state, build the job descriptor
  ssfb_front #(
    .DIGITS      (DIGITS),
    .CLEAR_BYTES (CLEAR_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cmd        (in_tuser),
    .number     (in_tdata[15:0]),
    .dot_select (in_tdata[17:16]),
    .param_num  (in_tdata[25:18]),
    .level      (in_tdata[29:26]),
    .push       (push),
    .push_desc  (push_desc),
    .q_full     (q_full)
  );

  // Queue: decouple conversion from byte emission
  ssfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // Back: emit the frames, one byte per transaction
  ssfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // The front end never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("descriptor pushed into full queue");

  // Every command's final byte closes a frame
  a_last_has_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("final byte without stop condition");

  // A start without stop only opens an address frame
  a_addr_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && !out_tuser[1] |-> out_tdata == ssfb_pkg::BYTE_ADDRESS)
    else $error("open frame does not start with address byte");

  // A popped job was present in the queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule
